// ----- design/tme_pkg.sv -----
package tme_pkg;

    // Instruction encodings as they arrive on the input channel
    localparam logic [3:0] OP_LEFT  = 4'd0;
    localparam logic [3:0] OP_RIGHT = 4'd1;
    localparam logic [3:0] OP_READ  = 4'd2;
    localparam logic [3:0] OP_OUT   = 4'd3;
    localparam logic [3:0] OP_SUB   = 4'd4;
    localparam logic [3:0] OP_ADD   = 4'd5;
    localparam logic [3:0] OP_OPEN  = 4'd6;
    localparam logic [3:0] OP_CLOSE = 4'd7;
    localparam logic [3:0] OP_END   = 4'd8;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_HALT = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        K_LEFT  = 4'd0,
        K_RIGHT = 4'd1,
        K_READ  = 4'd2,
        K_WRITE = 4'd3,
        K_SUB   = 4'd4,
        K_ADD   = 4'd5,
        K_OPEN  = 4'd6,
        K_CLOSE = 4'd7,
        K_END   = 4'd8,
        K_BAD   = 4'd9
    } kind_t;

    // Decoded instruction handed from the front to the back
    typedef struct packed {
        kind_t       kind;
        logic [15:0] tgt_next;   // jump target plus one, already wrapped
        logic [8:0]  rd_val;
    } entry_t;

endpackage

// ----- design/tape_machine_execute_unit.sv -----
// A result passes the front register, the queue and the output register.
// Throughput: one instruction per cycle unless output back-pressure or clearing
// stalls it; a pointer move's cell read is forwarded from the tape read port.
// Reset: synchronous, active low; clears pointer, index and queue, then sweeps
// every tape cell to zero with s_ready low.
module tape_machine_execute_unit #(
    parameter int TAPE_CELLS    = 32768,
    parameter int PROGRAM_DEPTH = 65536
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [3:0]        s_op_code,
    input  logic [15:0]       s_jump_target,
    input  logic signed [8:0] s_read_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [15:0]       m_next_index,
    output logic [7:0]        m_out_byte,
    output logic              m_out_valid,
    output logic              m_read_taken,
    output logic [1:0]        m_run_status
);
    import tme_pkg::*;

    logic              push;
    entry_t            push_data;
    logic              pop;
    logic              head_valid;
    entry_t            head_data;
    logic [QCNT_W-1:0] q_count;
    logic              clear_busy;

    tme_front #(
        .PROGRAM_DEPTH (PROGRAM_DEPTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op_code     (s_op_code),
        .s_jump_target (s_jump_target),
        .s_read_value  (s_read_value),
        .clear_busy    (clear_busy),
        .q_count       (q_count),
        .push          (push),
        .push_data     (push_data)
    );

    tme_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data),
        .count      (q_count)
    );

    tme_back #(
        .TAPE_CELLS    (TAPE_CELLS),
        .PROGRAM_DEPTH (PROGRAM_DEPTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_valid   (head_valid),
        .head_data    (head_data),
        .pop          (pop),
        .clear_busy   (clear_busy),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_next_index (m_next_index),
        .m_out_byte   (m_out_byte),
        .m_out_valid  (m_out_valid),
        .m_read_taken (m_read_taken),
        .m_run_status (m_run_status)
    );

endmodule

// ----- design/tme_front.sv -----
module tme_front #(
    parameter int PROGRAM_DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [3:0]               s_op_code,
    input  logic [15:0]              s_jump_target,
    input  logic signed [8:0]        s_read_value,
    input  logic                     clear_busy,
    input  logic [tme_pkg::QCNT_W-1:0] q_count,
    output logic                     push,
    output tme_pkg::entry_t          push_data
);
    import tme_pkg::*;

    logic              f_valid_reg;
    kind_t             f_kind_reg;
    logic [8:0]        f_rd_reg;
    logic [16:0]       f_t1_reg;
    logic [16:0]       t1;
    logic [15:0]       red_tgt;
    kind_t             kind;
    logic [QCNT_W:0]   used;
    logic              accept;

    // Count items already committed to the queue so a new beat always finds room
    assign used    = {1'b0, q_count} + (QCNT_W + 1)'(f_valid_reg);
    assign s_ready = !clear_busy && (used < (QCNT_W + 1)'(QUEUE_DEPTH));
    assign accept  = s_valid && s_ready;
    assign t1      = {1'b0, s_jump_target} + 17'd1;

    always_comb begin
        case (s_op_code)
            OP_LEFT:  kind = K_LEFT;
            OP_RIGHT: kind = K_RIGHT;
            OP_READ:  kind = K_READ;
            OP_OUT:   kind = K_WRITE;
            OP_SUB:   kind = K_SUB;
            OP_ADD:   kind = K_ADD;
            OP_OPEN:  kind = K_OPEN;
            OP_CLOSE: kind = K_CLOSE;
            OP_END:   kind = K_END;
            default:  kind = K_BAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            f_kind_reg <= kind;
            f_rd_reg   <= s_read_value;
            f_t1_reg   <= t1;
        end
    end

    // Wrap target plus one into the program space
    generate
        if (PROGRAM_DEPTH > 65536) begin : g_wide
            assign red_tgt = f_t1_reg[15:0];
        end else if ((PROGRAM_DEPTH & (PROGRAM_DEPTH - 1)) == 0) begin : g_pow2
            localparam logic [16:0] MASK = 17'(PROGRAM_DEPTH - 1);
            logic [16:0] masked;
            assign masked  = f_t1_reg & MASK;
            assign red_tgt = masked[15:0];
        end else begin : g_recip
            localparam int          SH    = 17 + $clog2(PROGRAM_DEPTH);
            localparam logic [63:0] MUL_K = ((64'd1 << SH) + 64'(PROGRAM_DEPTH) - 64'd1)
                                            / 64'(PROGRAM_DEPTH);
            localparam logic [16:0] DEP   = 17'(PROGRAM_DEPTH);
            logic [34:0] prod;
            logic [16:0] f_quo_reg;
            logic [33:0] qd;
            logic [16:0] rem;
            logic [16:0] rem_fix;

            // Quotient by reciprocal on the way in, remainder on the way out
            assign prod = 35'(t1) * 35'(MUL_K[17:0]);

            always_ff @(posedge aclk) begin
                if (accept) begin
                    f_quo_reg <= 17'(prod >> SH);
                end
            end

            assign qd      = 34'(f_quo_reg) * 34'(DEP);
            assign rem     = f_t1_reg - qd[16:0];
            assign rem_fix = (rem >= DEP) ? (rem - DEP) : rem;
            assign red_tgt = rem_fix[15:0];
        end
    endgenerate

    assign push               = f_valid_reg;
    assign push_data.kind     = f_kind_reg;
    assign push_data.tgt_next = red_tgt;
    assign push_data.rd_val   = f_rd_reg;

endmodule

// ----- design/tme_queue.sv -----
module tme_queue (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  tme_pkg::entry_t            push_data,
    input  logic                       pop,
    output logic                       head_valid,
    output tme_pkg::entry_t            head_data,
    output logic [tme_pkg::QCNT_W-1:0] count
);
    import tme_pkg::*;

    entry_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];
    assign count      = count_reg;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- design/tme_back.sv -----
module tme_back #(
    parameter int TAPE_CELLS    = 32768,
    parameter int PROGRAM_DEPTH = 65536
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             head_valid,
    input  tme_pkg::entry_t  head_data,
    output logic             pop,
    output logic             clear_busy,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [15:0]      m_next_index,
    output logic [7:0]       m_out_byte,
    output logic             m_out_valid,
    output logic             m_read_taken,
    output logic [1:0]       m_run_status
);
    import tme_pkg::*;

    localparam int              PTR_W     = $clog2(TAPE_CELLS);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(TAPE_CELLS - 1);
    localparam logic [16:0]     IDX_LIMIT = (PROGRAM_DEPTH > 65536) ? 17'h1FFFF
                                                                    : 17'(PROGRAM_DEPTH);

    logic [31:0]      tape_mem [TAPE_CELLS];
    logic [31:0]      rd_data_reg;

    logic             clr_active_reg;
    logic [PTR_W-1:0] clr_addr_reg;

    logic [PTR_W-1:0] ptr_reg;
    logic [PTR_W-1:0] ptr_next;
    logic [15:0]      idx_reg;
    logic [15:0]      idx_next;
    logic [31:0]      cell_reg;
    logic             load_pending_reg;

    logic             m_valid_reg;
    logic [15:0]      m_next_index_reg;
    logic [7:0]       m_out_byte_reg;
    logic             m_out_valid_reg;
    logic             m_read_taken_reg;
    logic [1:0]       m_run_status_reg;

    logic             exec;
    logic [31:0]      cell_cur;
    logic [31:0]      cell_new;
    logic             cell_we;
    logic             is_move;
    logic [16:0]      idx_inc;
    logic [15:0]      idx_adv;
    logic [7:0]       byte_out;
    logic             byte_valid;
    logic             taken;
    logic [1:0]       status;

    logic             mem_we;
    logic [PTR_W-1:0] mem_waddr;
    logic [31:0]      mem_wdata;

    assign exec       = head_valid && !clr_active_reg && (!m_valid_reg || m_ready);
    assign pop        = exec;
    assign clear_busy = clr_active_reg;

    // After a pointer move the fresh cell comes straight from the read port
    assign cell_cur = load_pending_reg ? rd_data_reg : cell_reg;

    assign idx_inc = {1'b0, idx_reg} + 17'd1;
    assign idx_adv = (idx_inc >= IDX_LIMIT) ? 16'd0 : idx_inc[15:0];

    always_comb begin
        cell_new   = cell_cur;
        cell_we    = 1'b0;
        is_move    = 1'b0;
        ptr_next   = ptr_reg;
        idx_next   = idx_adv;
        byte_out   = 8'd0;
        byte_valid = 1'b0;
        taken      = 1'b0;
        status     = ST_RUN;
        case (head_data.kind)
            K_LEFT: begin
                is_move  = 1'b1;
                ptr_next = (ptr_reg == '0) ? PTR_LAST : ptr_reg - 1'b1;
            end
            K_RIGHT: begin
                is_move  = 1'b1;
                ptr_next = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
            end
            K_READ: begin
                cell_new = {{23{head_data.rd_val[8]}}, head_data.rd_val};
                cell_we  = 1'b1;
                taken    = 1'b1;
            end
            K_WRITE: begin
                byte_out   = cell_cur[7:0];
                byte_valid = 1'b1;
            end
            K_SUB: begin
                cell_new = cell_cur - 32'd1;
                cell_we  = 1'b1;
            end
            K_ADD: begin
                cell_new = cell_cur + 32'd1;
                cell_we  = 1'b1;
            end
            K_OPEN: begin
                if (cell_cur == 32'd0) begin
                    idx_next = head_data.tgt_next;
                end
            end
            K_CLOSE: begin
                if (cell_cur != 32'd0) begin
                    idx_next = head_data.tgt_next;
                end
            end
            K_END: begin
                status   = ST_HALT;
                idx_next = idx_reg;
            end
            default: begin
                status   = ST_BAD;
                idx_next = idx_reg;
            end
        endcase
    end

    // Clearing pass owns the write port until it finishes
    assign mem_we    = clr_active_reg || (exec && cell_we);
    assign mem_waddr = clr_active_reg ? clr_addr_reg : ptr_reg;
    assign mem_wdata = clr_active_reg ? 32'd0 : cell_new;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            tape_mem[mem_waddr] <= mem_wdata;
        end
        if (exec && is_move) begin
            rd_data_reg <= tape_mem[ptr_next];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg   <= 1'b1;
            clr_addr_reg     <= '0;
            ptr_reg          <= '0;
            idx_reg          <= 16'd0;
            cell_reg         <= 32'd0;
            load_pending_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (clr_active_reg) begin
                if (clr_addr_reg == PTR_LAST) begin
                    clr_active_reg <= 1'b0;
                end
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (exec) begin
                ptr_reg          <= ptr_next;
                idx_reg          <= idx_next;
                cell_reg         <= cell_new;
                load_pending_reg <= is_move;
            end else if (load_pending_reg) begin
                cell_reg         <= rd_data_reg;
                load_pending_reg <= 1'b0;
            end
            if (exec) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (exec) begin
            m_next_index_reg <= idx_next;
            m_out_byte_reg   <= byte_out;
            m_out_valid_reg  <= byte_valid;
            m_read_taken_reg <= taken;
            m_run_status_reg <= status;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_next_index = m_next_index_reg;
    assign m_out_byte   = m_out_byte_reg;
    assign m_out_valid  = m_out_valid_reg;
    assign m_read_taken = m_read_taken_reg;
    assign m_run_status = m_run_status_reg;

endmodule

// ----- verif/tb_tape_machine_execute_unit.sv -----
module tb_tape_machine_execute_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tme_pkg::*;

    localparam int TAPE_CELLS    = 32768;
    localparam int PROGRAM_DEPTH = 65536;

    typedef struct {
        logic [15:0] next_index;
        logic [7:0]  out_byte;
        logic        out_valid;
        logic        read_taken;
        logic [1:0]  run_status;
    } exec_result_t;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic [3:0]        s_op_code     = '0;
    logic [15:0]       s_jump_target = '0;
    logic signed [8:0] s_read_value  = '0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic [15:0]       m_next_index;
    logic [7:0]        m_out_byte;
    logic              m_out_valid;
    logic              m_read_taken;
    logic [1:0]        m_run_status;

    // Shadow of the machine state
    logic [31:0]  tape_shadow [0:TAPE_CELLS-1];
    logic [14:0]  ptr_shadow;
    logic [15:0]  index_shadow;

    exec_result_t pending_results [$];
    int           fail_count  = 0;
    int           burst_left  = 0;
    int           ready_pct   = 100;
    int           ready_phase = 0;

    tape_machine_execute_unit #(
        .TAPE_CELLS   (TAPE_CELLS),
        .PROGRAM_DEPTH(PROGRAM_DEPTH)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op_code    (s_op_code),
        .s_jump_target(s_jump_target),
        .s_read_value (s_read_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_next_index (m_next_index),
        .m_out_byte   (m_out_byte),
        .m_out_valid  (m_out_valid),
        .m_read_taken (m_read_taken),
        .m_run_status (m_run_status)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        for (int i = 0; i < TAPE_CELLS; i++) tape_shadow[i] = '0;
        ptr_shadow   = '0;
        index_shadow = '0;
    end

    function automatic exec_result_t execute_instr(input logic [3:0] op,
                                                   input logic [15:0] tgt,
                                                   input logic [8:0] rv);
        exec_result_t res;
        logic [15:0]  here;
        res.out_byte   = '0;
        res.out_valid  = 1'b0;
        res.read_taken = 1'b0;
        res.run_status = ST_RUN;
        here = index_shadow;
        case (op)
            // The pointer is exactly 15 bits wide, so moves wrap on their own
            OP_LEFT:  ptr_shadow = ptr_shadow - 15'd1;
            OP_RIGHT: ptr_shadow = ptr_shadow + 15'd1;
            OP_READ: begin
                tape_shadow[ptr_shadow] = {{23{rv[8]}}, rv};
                res.read_taken = 1'b1;
            end
            OP_OUT: begin
                res.out_byte  = tape_shadow[ptr_shadow][7:0];
                res.out_valid = 1'b1;
            end
            OP_SUB:   tape_shadow[ptr_shadow] = tape_shadow[ptr_shadow] - 32'd1;
            OP_ADD:   tape_shadow[ptr_shadow] = tape_shadow[ptr_shadow] + 32'd1;
            OP_OPEN: begin
                if (tape_shadow[ptr_shadow] == 32'd0) here = tgt;
            end
            OP_CLOSE: begin
                if (tape_shadow[ptr_shadow] != 32'd0) here = tgt;
            end
            OP_END:   res.run_status = ST_HALT;
            default:  res.run_status = ST_BAD;
        endcase
        if (res.run_status == ST_RUN) index_shadow = here + 16'd1;
        res.next_index = index_shadow;
        return res;
    endfunction

    task automatic send_instr(input logic [3:0] op, input logic [15:0] tgt,
                              input logic [8:0] rv);
        s_valid       <= 1'b1;
        s_op_code     <= op;
        s_jump_target <= tgt;
        s_read_value  <= rv;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(execute_instr(op, tgt, rv));
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end else begin
            burst_left--;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : check_results
        exec_result_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing pending");
                fail_count++;
            end else begin
                exp_res = pending_results.pop_front();
                check_field("next_index", 32'(exp_res.next_index), 32'(m_next_index));
                check_field("out_byte",   32'(exp_res.out_byte),   32'(m_out_byte));
                check_field("out_valid",  32'(exp_res.out_valid),  32'(m_out_valid));
                check_field("read_taken", 32'(exp_res.read_taken), 32'(m_read_taken));
                check_field("run_status", 32'(exp_res.run_status), 32'(m_run_status));
            end
        end
    end

    // Receiver: phases of differing readiness, from always ready to mostly stalled
    always @(posedge aclk) begin
        if (ready_phase == 0) begin
            case ($urandom_range(0, 3))
                0: ready_pct = 100;
                1: ready_pct = 75;
                2: ready_pct = 40;
                default: ready_pct = 10;
            endcase
            ready_phase = $urandom_range(50, 300);
        end else begin
            ready_phase--;
        end
        m_ready <= ($urandom_range(1, 100) <= ready_pct);
    end

    task automatic test_pointer_wrap();
        send_instr(OP_LEFT, 16'd0, 9'd0);
        send_instr(OP_ADD, 16'd0, 9'd0);
        send_instr(OP_OUT, 16'd0, 9'd0);
        send_instr(OP_RIGHT, 16'd0, 9'd0);
        send_instr(OP_OUT, 16'd0, 9'd0);
    endtask

    task automatic test_cell_wrap();
        send_instr(OP_SUB, 16'd0, 9'd0);
        send_instr(OP_OUT, 16'd0, 9'd0);
        send_instr(OP_ADD, 16'd0, 9'd0);
        send_instr(OP_OUT, 16'd0, 9'd0);
    endtask

    task automatic test_read_sign();
        // end of input, then the most negative code, then the largest byte
        send_instr(OP_READ, 16'hFFFF, 9'h1FF);
        send_instr(OP_OUT, 16'd0, 9'd0);
        send_instr(OP_READ, 16'd0, 9'h100);
        send_instr(OP_OUT, 16'd0, 9'd0);
        send_instr(OP_READ, 16'd0, 9'h0FF);
    endtask

    task automatic test_brackets();
        // jump to the last index so the advance wraps to zero
        send_instr(OP_CLOSE, 16'hFFFF, 9'd0);
        send_instr(OP_OPEN, 16'd1234, 9'd0);
        send_instr(OP_READ, 16'd0, 9'd0);
        send_instr(OP_OPEN, 16'hFFFF, 9'd0);
        send_instr(OP_CLOSE, 16'd0, 9'd0);
    endtask

    task automatic test_halt_and_unknown();
        send_instr(OP_END, 16'hFFFF, 9'h1FF);
        send_instr(OP_END, 16'd0, 9'd0);
        send_instr(4'd9, 16'd7, 9'd7);
        send_instr(4'd15, 16'hFFFF, 9'h1FF);
        // execution resumes after a halt
        send_instr(OP_ADD, 16'd0, 9'd0);
    endtask

    task automatic test_random_program(input int n_items);
        logic [3:0]  op;
        logic [15:0] tgt;
        int          pick;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 88) op = 4'($urandom_range(0, 7));
            else if (pick < 94) op = OP_END;
            else op = 4'($urandom_range(9, 15));
            case ($urandom_range(0, 3))
                0: tgt = 16'hFFFF;
                1: tgt = 16'(index_shadow + $urandom_range(0, 8));
                default: tgt = 16'($urandom);
            endcase
            send_instr(op, tgt, 9'($urandom_range(0, 511)));
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_pointer_wrap();
        test_cell_wrap();
        test_read_sign();
        test_brackets();
        test_halt_and_unknown();
        test_random_program(1800);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #16_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
